/* rtl/core/luma_threshold_binarizer_defines.svh */
// Assertion macros for the luma threshold binariser.
// Taken in by the top level; depends on a clock named clk and a reset named rst.
`ifndef LUMA_THRESHOLD_BINARIZER_DEFINES_SVH
`define LUMA_THRESHOLD_BINARIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("luma binariser check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("luma binariser check failed");

`endif

/* rtl/core/ltb_pkg.sv */
// Shared types, codes and constants of the luma threshold binariser.
// Used by ltb_palette and luma_threshold_binarizer; depends on nothing else.
package ltb_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_LINE_WIDTH_DEF  = 4096;

  localparam int CFG_DW   = 13;
  localparam int COLOR_W  = 24;
  localparam int PROD_W   = 20;
  localparam int SUM_W    = 21;

  localparam logic [PROD_W-1:0] WEIGHT_R = PROD_W'(872);
  localparam logic [PROD_W-1:0] WEIGHT_G = PROD_W'(2930);
  localparam logic [PROD_W-1:0] WEIGHT_B = PROD_W'(296);

  localparam logic [COLOR_W-1:0] WHITE_RGB888  = 24'hffffff;
  localparam logic [COLOR_W-1:0] WHITE_RGB565  = 24'h00ffff;
  localparam logic [COLOR_W-1:0] WHITE_PALETTE = 24'h0000ff;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_PIXEL_FMT   = 2'd1,
    REG_OUTPUT_MODE = 2'd2,
    REG_LINE_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_RGB888   = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_PALETTE  = 2'd2,
    FMT_RESERVED = 2'd3
  } pixel_fmt_t;

  typedef enum logic {
    MODE_PER_PIXEL = 1'b0,
    MODE_PACKED    = 1'b1
  } out_mode_t;

  typedef enum logic {
    REQ_PALETTE = 1'b0,
    REQ_PIXEL   = 1'b1
  } req_t;

endpackage

/* rtl/core/luma_threshold_binarizer.sv */
// Top level of the luma threshold binariser: input pipeline, luma sum, line packing.
// Depends on ltb_pkg, ltb_palette and luma_threshold_binarizer_defines.svh.
//
// Usage: items arrive on the in_valid/in_ready channel. A palette write item
// (req_type 0) stores entry_color at entry_index and gives no result. A pixel
// item (req_type 1) is decoded by pixel_format, its luma sum is compared with
// threshold*4096, and it yields a black/white value in per-pixel mode, or one
// bit of a packed byte in packed mode, where a byte leaves every eight pixels
// and at the end of each line. Results leave on out_valid/out_ready.
// From the accepting edge an item passes the registered palette read, the
// weighted product registers, and then the sum and compare into the output
// register. One item is taken every cycle while the receiver accepts; the
// pipeline advances as one, so a stalled output transfer holds every stage
// and drops in_ready.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Reset clears the pipeline, the line position and the packed bits, and sets
// the registers to threshold 128, rgb888, per-pixel mode and 640 pixels a
// line. The palette memory is not cleared and must be written before use.
`include "luma_threshold_binarizer_defines.svh"

module luma_threshold_binarizer #(
  parameter int PALETTE_ENTRIES = ltb_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_LINE_WIDTH  = ltb_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [ltb_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [23:0]                 pixel_value,
  input  logic [7:0]                  entry_index,
  input  logic [23:0]                 entry_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [23:0]                 out_value,
  output logic                        end_of_line
);
  import ltb_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int EW = (CW > CFG_DW) ? CW : CFG_DW;

  logic [7:0]        threshold;
  pixel_fmt_t        pixel_format;
  out_mode_t         output_mode;
  logic [CFG_DW-1:0] line_width;

  logic en;
  logic in_fire;
  logic wr_ok;
  logic rd_ok;

  logic               s1_valid;
  logic [23:0]        s1_code;
  logic               s1_idx_ok;
  logic [COLOR_W-1:0] rd_data;
  logic [COLOR_W-1:0] color;
  logic [7:0]         r, g, b;

  logic              s2_valid;
  logic [PROD_W-1:0] pr, pg, pb;
  logic [SUM_W-1:0]  sum;
  logic              dark;

  logic [CW-1:0] column_count;
  logic [7:0]    pack_byte;
  logic [2:0]    bit_position;
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] eff_width;
  logic [EW:0]   col_inc;
  logic          last;
  logic          emit;
  logic [7:0]    pack_or;
  logic [COLOR_W-1:0] white;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= 8'd128;
      pixel_format <= FMT_RGB888;
      output_mode  <= MODE_PER_PIXEL;
      line_width   <= CFG_DW'(640);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   threshold    <= cfg_data[7:0];
        REG_PIXEL_FMT:   pixel_format <= pixel_fmt_t'(cfg_data[1:0]);
        REG_OUTPUT_MODE: output_mode  <= out_mode_t'(cfg_data[0]);
        REG_LINE_WIDTH:  line_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;
  assign wr_ok    = {1'b0, entry_index} < 9'(PALETTE_ENTRIES);
  assign rd_ok    = {1'b0, pixel_value[7:0]} < 9'(PALETTE_ENTRIES);

  ltb_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (in_fire && (req_t'(req_type) == REQ_PALETTE) && wr_ok),
    .wr_addr (entry_index[AW-1:0]),
    .wr_data (entry_color),
    .rd_en   (en),
    .rd_addr (pixel_value[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_fire && (req_t'(req_type) == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_code   <= pixel_value;
      s1_idx_ok <= rd_ok;
    end
  end

  always_comb begin
    color = s1_code;
    if (pixel_format == FMT_PALETTE) begin
      color = s1_idx_ok ? rd_data : '0;
    end
    r = color[23:16];
    g = color[15:8];
    b = color[7:0];
    if (pixel_format == FMT_RGB565) begin
      r = {s1_code[15:11], 3'b000};
      g = {s1_code[10:5], 2'b00};
      b = {s1_code[4:0], 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr <= PROD_W'(r) * WEIGHT_R;
      pg <= PROD_W'(g) * WEIGHT_G;
      pb <= PROD_W'(b) * WEIGHT_B;
    end
  end

  always_comb begin
    sum  = SUM_W'(pr) + SUM_W'(pg) + SUM_W'(pb);
    dark = sum < SUM_W'({threshold, 12'h000});

    lw_ext = EW'(line_width);
    if (lw_ext == '0) begin
      eff_width = EW'(1);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      eff_width = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_width = lw_ext;
    end
    col_inc = (EW + 1)'(column_count) + (EW + 1)'(1);
    last    = col_inc >= (EW + 1)'(eff_width);

    pack_or = pack_byte | (dark ? (8'h80 >> bit_position) : 8'h00);
    emit    = (output_mode == MODE_PER_PIXEL) || last || (bit_position == 3'd7);

    case (pixel_format)
      FMT_RGB565:  white = WHITE_RGB565;
      FMT_PALETTE: white = WHITE_PALETTE;
      default:     white = WHITE_RGB888;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      pack_byte    <= '0;
      bit_position <= '0;
    end else if (en && s2_valid) begin
      if (last) begin
        column_count <= '0;
        pack_byte    <= '0;
        bit_position <= '0;
      end else begin
        column_count <= column_count + CW'(1);
        if (output_mode == MODE_PACKED) begin
          if (bit_position == 3'd7) begin
            pack_byte    <= '0;
            bit_position <= '0;
          end else begin
            pack_byte    <= pack_or;
            bit_position <= bit_position + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      end_of_line <= last;
      if (output_mode == MODE_PACKED) begin
        out_value <= COLOR_W'(pack_or);
      end else begin
        out_value <= dark ? '0 : white;
      end
    end
  end

  `LTB_ASSERT_SAME(a_out_from_pipe, $rose(out_valid), $past(s2_valid))
  `LTB_ASSERT_SAME(a_packed_byte_only, out_valid && (output_mode == MODE_PACKED),
    out_value[23:8] == 16'h0000)
  `LTB_ASSERT_SAME(a_rgb565_levels,
    out_valid && (output_mode == MODE_PER_PIXEL) && (pixel_format == FMT_RGB565),
    (out_value == '0) || (out_value == WHITE_RGB565))

endmodule

/* rtl/core/ltb_palette.sv */
// Palette memory of the luma threshold binariser: one write and one read port,
// read data registered. Depends on ltb_pkg.
module ltb_palette #(
  parameter int ENTRIES = ltb_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [ltb_pkg::COLOR_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [ltb_pkg::COLOR_W-1:0]  rd_data
);
  import ltb_pkg::*;

  logic [COLOR_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
